>>> design/unsorted_priority_queue_core_assert.svh
// Assertion macros shared by the priority queue RTL.
`ifndef UNSORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define UNSORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UPQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define UPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/upq_pkg.sv
// Package: sizes, entry type, codes and sequencer states of the priority queue.
`default_nettype none

package upq_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int VALUE_W  = 32;
   localparam int PRIO_W   = 16;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 7;

   // opcodes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic signed [PRIO_W-1:0]  prio;
      logic signed [VALUE_W-1:0] value;
   } upq_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_SCAN,
      ST_SHIFT,
      ST_REPLY
   } upq_state_type;

endpackage

`default_nettype wire

>>> design/upq_req_if.sv
// Request channel interface: opcode and entry to push.
`default_nettype none

interface upq_req_if
   import upq_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic signed [VALUE_W-1:0] item_value;
   logic signed [PRIO_W-1:0]  item_priority;

   modport source (output valid, output opcode, output item_value,
                   output item_priority, input ready);
   modport sink   (input valid, input opcode, input item_value,
                   input item_priority, output ready);
endinterface

`default_nettype wire

>>> design/upq_rsp_if.sv
// Response channel interface: removed entry, status and occupancy.
`default_nettype none

interface upq_rsp_if
   import upq_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] out_value;
   logic signed [PRIO_W-1:0]  out_priority;
   logic [STATUS_W-1:0]       status;
   logic [OCC_W-1:0]          occupancy;

   modport source (output valid, output out_value, output out_priority,
                   output status, output occupancy, input ready);
   modport sink   (input valid, input out_value, input out_priority,
                   input status, input occupancy, output ready);
endinterface

`default_nettype wire

>>> design/unsorted_priority_queue_core.sv
// Top level: unsorted-array priority queue with a scan sequencer over a one-read, one-write store.
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+---------------------------------------------
//   req_ch   | in  | valid/ready  | opcode, item_value, item_priority
//   rsp_ch   | out | valid/ready  | out_value, out_priority, status, occupancy
//
// A push goes through the push and reply steps. A pop of a queue holding
// N entries scans every entry with one memory read per cycle, then closes the
// gap behind the winner at index best with one read/write per cycle. The
// sequencer works on one request at a time.
// Reset clears the entry count and control state; the store needs no clearing pass.
// The result sits in an output register; a new transaction is accepted while
// it waits, and that transaction stalls in its reply step until the slot frees.
`default_nettype none

`include "unsorted_priority_queue_core_assert.svh"

module unsorted_priority_queue_core
   import upq_pkg::*;
   (
   input  wire        clock,
   input  wire        reset,
   upq_req_if.sink    req_ch,
   upq_rsp_if.source  rsp_ch
   );

   // entry store
   upq_entry_type mem [CAPACITY];

   upq_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                op_ff, op_in;
   upq_entry_type       item_ff, item_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   upq_entry_type       best_ff, best_in;
   logic                have_best_ff, have_best_in;
   upq_entry_type       res_entry_ff, res_entry_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   upq_entry_type       rsp_entry_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [OCC_W-1:0]    rsp_occ_ff;
   upq_entry_type       rd_data_ff;

   logic                accept;
   logic                rsp_free;
   logic                issue_ok;
   logic                drain_done;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   upq_entry_type       wr_data;
   logic                rsp_load;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign issue_ok     = (idx_ff < count_ff);
   assign drain_done   = !issue_ok && !rd_pend_ff;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_value    = rsp_entry_ff.value;
   assign rsp_ch.out_priority = rsp_entry_ff.prio;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.occupancy    = rsp_occ_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_ch.opcode == OP_POP) ? ST_SCAN : ST_PUSH;
            end
         end
         ST_PUSH: begin
            state_in = ST_REPLY;
         end
         ST_SCAN: begin
            if (count_ff == '0) begin
               state_in = ST_REPLY;
            end else if (drain_done) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (drain_done) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath control and the shared compare
   always_comb begin
      count_in      = count_ff;
      op_in         = op_ff;
      item_in       = item_ff;
      idx_in        = idx_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      have_best_in  = have_best_ff;
      res_entry_in  = res_entry_ff;
      res_status_in = res_status_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = item_ff;
      rsp_load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in         = req_ch.opcode;
               item_in.value = req_ch.item_value;
               item_in.prio  = req_ch.item_priority;
               res_entry_in  = '0;
               res_status_in = STATUS_OK;
               idx_in        = '0;
               have_best_in  = 1'b0;
            end
         end
         ST_PUSH: begin
            if (count_ff < CNT_W'(CAPACITY)) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end else begin
               res_status_in = STATUS_FULL;
            end
         end
         ST_SCAN: begin
            if (count_ff == '0) begin
               res_status_in = STATUS_EMPTY;
            end else begin
               // issue next read
               rd_pend_in = issue_ok;
               if (issue_ok) begin
                  rd_en     = 1'b1;
                  rd_idx_in = idx_ff[IDX_W-1:0];
                  idx_in    = idx_ff + CNT_W'(1);
               end
               // ties go to the later entry
               if (rd_pend_ff && (!have_best_ff ||
                   ($signed(rd_data_ff.prio) >= $signed(best_ff.prio)))) begin
                  best_in      = rd_data_ff;
                  best_idx_in  = rd_idx_ff;
                  have_best_in = 1'b1;
               end
               if (drain_done) begin
                  idx_in       = CNT_W'(best_idx_ff) + CNT_W'(1);
                  res_entry_in = best_ff;
               end
            end
         end
         ST_SHIFT: begin
            // read entry i+1, write it to i in the next cycle
            rd_pend_in = issue_ok;
            if (issue_ok) begin
               rd_en     = 1'b1;
               rd_idx_in = idx_ff[IDX_W-1:0];
               idx_in    = idx_ff + CNT_W'(1);
            end
            if (rd_pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff - IDX_W'(1);
               wr_data = rd_data_ff;
            end
            if (drain_done) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         ST_REPLY: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   // output valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         have_best_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         have_best_ff <= have_best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      item_ff       <= item_in;
      idx_ff        <= idx_in;
      rd_idx_ff     <= rd_idx_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      res_entry_ff  <= res_entry_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_entry_ff  <= res_entry_ff;
         rsp_status_ff <= res_status_ff;
         rsp_occ_ff    <= OCC_W'(count_ff);
      end
   end

   // store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   `UPQ_ASSERT_NOW(a_count_cap, 1'b1, count_ff <= CNT_W'(CAPACITY), "entry count above capacity")
   `UPQ_ASSERT_NOW(a_scan_no_write, state_ff == ST_SCAN, !wr_en, "store written during scan")
   `UPQ_ASSERT_NEXT(a_pop_shrinks, (state_ff == ST_SHIFT) && drain_done, count_ff == $past(count_ff) - CNT_W'(1), "pop did not remove an entry")
   `UPQ_ASSERT_NOW(a_full_status, (state_ff == ST_REPLY) && (res_status_ff == STATUS_FULL), count_ff == CNT_W'(CAPACITY), "full status with free room")
   `UPQ_ASSERT_NOW(a_push_op, state_ff == ST_PUSH, op_ff == OP_PUSH, "push step entered for a pop")

endmodule

`default_nettype wire
